>>> sv/fisheye_remap_address_defines.svh
// Assertion macros used by the fisheye remap address generator.
`ifndef FISHEYE_REMAP_ADDRESS_DEFINES_SVH
`define FISHEYE_REMAP_ADDRESS_DEFINES_SVH
// Same-cycle implication, checked at every rising edge outside reset.
`define FRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define FRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/fra_pkg.sv
// Shared constants, types and register codes of the fisheye remap address generator.
package fra_pkg;

  localparam int COORD_BITS = 12;
  localparam int IMG_BITS   = 13;
  localparam int CFG_IDX_BITS = 3;
  localparam int DX_BITS    = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int D2_BITS    = SQ_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int R_BITS     = FRAC_BITS + 1;
  localparam int ROOT_BITS  = COORD_BITS + FRAC_BITS;
  localparam int SQREM_BITS = ROOT_BITS + 2;
  localparam int ACC_BITS   = 21;
  localparam int PROD_BITS  = ACC_BITS + R_BITS + 1;
  localparam int NUM_BITS   = COORD_BITS + 20;
  localparam int Q_BITS     = COORD_BITS + 1;
  localparam int OVF_BITS   = NUM_BITS - Q_BITS;
  localparam int OVCMP_BITS = (OVF_BITS > R_BITS) ? OVF_BITS : R_BITS;
  localparam int CMP_BITS   = (Q_BITS > IMG_BITS) ? Q_BITS : IMG_BITS;

  localparam int K_D2       = 3;
  localparam int RAD_LAT    = ROOT_BITS + R_BITS;
  localparam int K_R        = K_D2 + RAD_LAT;
  localparam int HORNER_LAT = 8;
  localparam int K_NR       = K_R + HORNER_LAT;
  localparam int K_NUM      = K_NR + 2;
  localparam int CDIV_LAT   = Q_BITS + 1;
  localparam int K_Q        = K_NUM + CDIV_LAT;

  localparam logic signed [ACC_BITS-1:0] COEF_A1 = ACC_BITS'(194224);
  localparam logic signed [ACC_BITS-1:0] COEF_A2 = ACC_BITS'(-337459);
  localparam logic signed [ACC_BITS-1:0] COEF_A3 = ACC_BITS'(325369);
  localparam logic signed [ACC_BITS-1:0] COEF_A4 = ACC_BITS'(-134868);

  localparam logic [COORD_BITS-1:0] RST_RADIUS = COORD_BITS'(1);
  localparam logic [IMG_BITS-1:0]   RST_IMG    = IMG_BITS'(4096);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_LENS_RADIUS  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]    px;
    logic [COORD_BITS-1:0]    py;
    logic signed [DX_BITS-1:0] dx;
    logic signed [DX_BITS-1:0] dy;
    logic                     zero;
    logic                     in_circle;
    logic                     nr_neg;
    logic                     r_zero;
  } side_t;

endpackage

>>> sv/fisheye_remap_address.sv
// Top level of the fisheye remap address generator.
// The input channel takes one output pixel coordinate per transaction and the
// result channel returns the source coordinate to sample, with remapped high
// when the lens correction was applied and low when the pixel maps to itself.
// Both channels use valid and ready; the configuration port writes the lens
// centre, lens radius and image size with a single-cycle write enable; the
// user must write it only while no transaction is in flight, which the block
// itself does not enforce. One transaction is accepted every cycle while the
// pipeline is not stalled; the design is a 72-stage pipeline: square root and
// radius divide one bit per stage, the Horner polynomial one multiply per two
// stages and the coordinate divide, after a magnitude stage, one quotient
// bit per stage.
// Reset clears every stage valid and the output valid, and returns the
// configuration registers to centre 0,0, radius 1 and a 4096 by 4096 image.
// When the receiver stalls, a result waits in the output register while the
// pipeline keeps moving until its last stage holds a transaction; then the
// whole pipeline and the input channel hold until the result is taken.
`include "fisheye_remap_address_defines.svh"
module fisheye_remap_address
  import fra_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_pixel_x,
  input  logic [COORD_BITS-1:0]   in_pixel_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_source_x,
  output logic [COORD_BITS-1:0]   out_source_y,
  output logic                    out_remapped,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [IMG_BITS-1:0]     cfg_wdata
);

  logic [COORD_BITS-1:0] center_x_r;
  logic [COORD_BITS-1:0] center_y_r;
  logic [COORD_BITS-1:0] lens_radius_r;
  logic [IMG_BITS-1:0]   image_width_r;
  logic [IMG_BITS-1:0]   image_height_r;
  logic [COORD_BITS-1:0] rad_eff;
  logic [SQ_BITS-1:0]    rad_sq_r;

  logic                  en;
  logic                  vld_r  [1:K_Q];
  side_t                 side_r [1:K_Q];
  side_t                 side_d2;
  side_t                 side_nr;
  logic signed [DX_BITS-1:0]   dx_in;
  logic signed [DX_BITS-1:0]   dy_in;
  logic signed [2*DX_BITS-1:0] sqx;
  logic signed [2*DX_BITS-1:0] sqy;
  logic [SQ_BITS-1:0]    dxx_r;
  logic [SQ_BITS-1:0]    dyy_r;
  logic [D2_BITS-1:0]    d2_r;
  logic [R_BITS-1:0]     r_rad;
  logic [R_BITS-1:0]     rh_r [K_R+1:K_NUM];
  logic signed [PROD_BITS-1:0] p1_r;
  logic signed [PROD_BITS-1:0] p2_r;
  logic signed [PROD_BITS-1:0] p3_r;
  logic signed [PROD_BITS-1:0] p4_r;
  logic signed [ACC_BITS-1:0]  acc1_r;
  logic signed [ACC_BITS-1:0]  acc2_r;
  logic signed [ACC_BITS-1:0]  acc3_r;
  logic signed [ACC_BITS-1:0]  nr_r;
  logic signed [COORD_BITS+R_BITS+1:0] pcx_r;
  logic signed [COORD_BITS+R_BITS+1:0] pcy_r;
  logic signed [ACC_BITS+DX_BITS-1:0]  pdx_r;
  logic signed [ACC_BITS+DX_BITS-1:0]  pdy_r;
  logic signed [NUM_BITS-1:0]  numx_r;
  logic signed [NUM_BITS-1:0]  numy_r;
  logic [Q_BITS-1:0]     qx;
  logic [Q_BITS-1:0]     qy;
  logic                  negx;
  logic                  negy;
  logic                  ovfx;
  logic                  ovfy;
  logic                  okx;
  logic                  oky;
  logic                  ok_bent;
  logic                  ok_ctr;
  side_t                 sd;
  logic                  out_load;
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] src_x_r;
  logic [COORD_BITS-1:0] src_y_r;
  logic                  remapped_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      lens_radius_r  <= RST_RADIUS;
      image_width_r  <= RST_IMG;
      image_height_r <= RST_IMG;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     center_x_r     <= cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Y:     center_y_r     <= cfg_wdata[COORD_BITS-1:0];
        REG_LENS_RADIUS:  lens_radius_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A zero radius behaves as a radius of one pixel.
  assign rad_eff = (lens_radius_r == '0) ? RST_RADIUS : lens_radius_r;

  always_ff @(posedge clk) begin
    rad_sq_r <= rad_eff * rad_eff;
  end

  assign en       = !vld_r[K_Q] || !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= K_Q; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int k = 2; k <= K_Q; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign dx_in = $signed({1'b0, in_pixel_x}) - $signed({1'b0, center_x_r});
  assign dy_in = $signed({1'b0, in_pixel_y}) - $signed({1'b0, center_y_r});
  assign sqx   = side_r[1].dx * side_r[1].dx;
  assign sqy   = side_r[1].dy * side_r[1].dy;

  always_comb begin
    side_d2           = side_r[K_D2];
    side_d2.zero      = (d2_r == '0);
    side_d2.in_circle = ({1'b0, rad_sq_r} >= d2_r);
    side_nr           = side_r[K_NR];
    side_nr.nr_neg    = nr_r[ACC_BITS-1];
    side_nr.r_zero    = (rh_r[K_NR] == '0);
  end

  fra_radius u_radius (
    .clk   (clk),
    .en    (en),
    .d2_in (d2_r[SQ_BITS-1:0]),
    .rad   (rad_eff),
    .r_out (r_rad)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= '{px: in_pixel_x, py: in_pixel_y, dx: dx_in, dy: dy_in,
                     zero: 1'b0, in_circle: 1'b0, nr_neg: 1'b0, r_zero: 1'b0};
      for (int k = 2; k <= K_Q; k++) begin
        if (k == K_D2 + 1) begin
          side_r[k] <= side_d2;
        end else if (k == K_NR + 1) begin
          side_r[k] <= side_nr;
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end

      dxx_r <= sqx[SQ_BITS-1:0];
      dyy_r <= sqy[SQ_BITS-1:0];
      d2_r  <= {1'b0, dxx_r} + {1'b0, dyy_r};

      rh_r[K_R+1] <= r_rad;
      for (int k = K_R + 2; k <= K_NUM; k++) begin
        rh_r[k] <= rh_r[k-1];
      end

      p1_r   <= COEF_A4 * $signed({1'b0, r_rad});
      acc1_r <= ACC_BITS'(p1_r >>> FRAC_BITS) + COEF_A3;
      p2_r   <= acc1_r * $signed({1'b0, rh_r[K_R+2]});
      acc2_r <= ACC_BITS'(p2_r >>> FRAC_BITS) + COEF_A2;
      p3_r   <= acc2_r * $signed({1'b0, rh_r[K_R+4]});
      acc3_r <= ACC_BITS'(p3_r >>> FRAC_BITS) + COEF_A1;
      p4_r   <= acc3_r * $signed({1'b0, rh_r[K_R+6]});
      nr_r   <= ACC_BITS'(p4_r >>> FRAC_BITS);

      pcx_r  <= $signed({1'b0, center_x_r}) * $signed({1'b0, rh_r[K_NR]});
      pcy_r  <= $signed({1'b0, center_y_r}) * $signed({1'b0, rh_r[K_NR]});
      pdx_r  <= nr_r * side_r[K_NR].dx;
      pdy_r  <= nr_r * side_r[K_NR].dy;
      numx_r <= NUM_BITS'(pcx_r) + NUM_BITS'(pdx_r);
      numy_r <= NUM_BITS'(pcy_r) + NUM_BITS'(pdy_r);
    end
  end

  fra_cdiv u_cdiv_x (
    .clk     (clk),
    .en      (en),
    .num     (numx_r),
    .den     (rh_r[K_NUM]),
    .q_out   (qx),
    .neg_out (negx),
    .ovf_out (ovfx)
  );

  fra_cdiv u_cdiv_y (
    .clk     (clk),
    .en      (en),
    .num     (numy_r),
    .den     (rh_r[K_NUM]),
    .q_out   (qy),
    .neg_out (negy),
    .ovf_out (ovfy)
  );

  assign sd  = side_r[K_Q];
  assign okx = !ovfx && !(negx && (qx != '0)) && !qx[Q_BITS-1] &&
               (CMP_BITS'(qx) < CMP_BITS'(image_width_r));
  assign oky = !ovfy && !(negy && (qy != '0)) && !qy[Q_BITS-1] &&
               (CMP_BITS'(qy) < CMP_BITS'(image_height_r));
  assign ok_bent = sd.in_circle && !sd.zero && !sd.nr_neg && !sd.r_zero && okx && oky;
  assign ok_ctr  = sd.zero &&
                   (CMP_BITS'(center_x_r) < CMP_BITS'(image_width_r)) &&
                   (CMP_BITS'(center_y_r) < CMP_BITS'(image_height_r));

  assign out_load = out_ready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld_r[K_Q];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld_r[K_Q]) begin
      if (ok_ctr) begin
        src_x_r <= center_x_r;
        src_y_r <= center_y_r;
      end else if (ok_bent) begin
        src_x_r <= qx[COORD_BITS-1:0];
        src_y_r <= qy[COORD_BITS-1:0];
      end else begin
        src_x_r <= sd.px;
        src_y_r <= sd.py;
      end
      remapped_r <= ok_ctr || ok_bent;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_source_x = src_x_r;
  assign out_source_y = src_y_r;
  assign out_remapped = remapped_r;

  `FRA_ASSERT_SAME(a_full_stall_blocks_input,
                   vld_r[K_Q] && out_valid_r && !out_ready, !in_ready,
                   "input accepted while the pipeline is stalled")
  `FRA_ASSERT_NEXT(a_accept_enters_pipe, in_valid && in_ready, vld_r[1],
                   "accepted transaction missing from the first stage")
  `FRA_ASSERT_SAME(a_remap_inside_image, out_valid_r && out_remapped,
                   (CMP_BITS'(out_source_x) < CMP_BITS'(image_width_r)) &&
                   (CMP_BITS'(out_source_y) < CMP_BITS'(image_height_r)),
                   "remapped source lies outside the image")

endmodule

>>> sv/fra_radius.sv
// Pipelined square root and normalising divide giving the Q1.16 radius.
module fra_radius
  import fra_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQ_BITS-1:0]    d2_in,
  input  logic [COORD_BITS-1:0] rad,
  output logic [R_BITS-1:0]     r_out
);

  logic [SQREM_BITS-1:0] sq_rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0]  sq_root_r [ROOT_BITS];
  logic [SQ_BITS-1:0]    sq_feed_r [ROOT_BITS];
  logic [COORD_BITS-1:0] dv_rem_r  [R_BITS];
  logic [R_BITS-1:0]     dv_q_r    [R_BITS];
  logic [R_BITS-1:0]     dv_low_r  [R_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sq
    logic [SQREM_BITS-1:0] rem_in;
    logic [SQREM_BITS-1:0] rem_sh;
    logic [SQREM_BITS-1:0] trial;
    logic [ROOT_BITS-1:0]  root_in;
    logic [SQ_BITS-1:0]    feed_in;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign feed_in = d2_in;
    end else begin : g_next
      assign rem_in  = sq_rem_r[i-1];
      assign root_in = sq_root_r[i-1];
      assign feed_in = sq_feed_r[i-1];
    end
    assign rem_sh = {rem_in[SQREM_BITS-3:0], feed_in[SQ_BITS-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          sq_rem_r[i]  <= rem_sh - trial;
          sq_root_r[i] <= {root_in[ROOT_BITS-2:0], 1'b1};
        end else begin
          sq_rem_r[i]  <= rem_sh;
          sq_root_r[i] <= {root_in[ROOT_BITS-2:0], 1'b0};
        end
        sq_feed_r[i] <= {feed_in[SQ_BITS-3:0], 2'b00};
      end
    end
  end

  for (genvar j = 0; j < R_BITS; j++) begin : g_dv
    logic [COORD_BITS-1:0] rem_in;
    logic [R_BITS-1:0]     q_in;
    logic [R_BITS-1:0]     low_in;
    logic [COORD_BITS:0]   t;
    if (j == 0) begin : g_first
      assign rem_in = COORD_BITS'(sq_root_r[ROOT_BITS-1][ROOT_BITS-1:R_BITS]);
      assign q_in   = '0;
      assign low_in = sq_root_r[ROOT_BITS-1][R_BITS-1:0];
    end else begin : g_next
      assign rem_in = dv_rem_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign low_in = dv_low_r[j-1];
    end
    assign t = {rem_in, low_in[R_BITS-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, rad}) begin
          dv_rem_r[j] <= COORD_BITS'(t - {1'b0, rad});
          dv_q_r[j]   <= {q_in[R_BITS-2:0], 1'b1};
        end else begin
          dv_rem_r[j] <= t[COORD_BITS-1:0];
          dv_q_r[j]   <= {q_in[R_BITS-2:0], 1'b0};
        end
        dv_low_r[j] <= {low_in[R_BITS-2:0], 1'b0};
      end
    end
  end

  assign r_out = dv_q_r[R_BITS-1];

endmodule

>>> sv/fra_cdiv.sv
// Pipelined signed-by-radius divide with truncation toward zero and range flag.
module fra_cdiv
  import fra_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [NUM_BITS-1:0] num,
  input  logic [R_BITS-1:0]          den,
  output logic [Q_BITS-1:0]          q_out,
  output logic                       neg_out,
  output logic                       ovf_out
);

  logic [NUM_BITS-1:0] mag;
  logic [NUM_BITS-1:0] mag0_r;
  logic [R_BITS-1:0]   den0_r;
  logic                sg0_r;
  logic                ovf0_r;
  logic [R_BITS-1:0]   rem_r [Q_BITS];
  logic [Q_BITS-1:0]   q_r   [Q_BITS];
  logic [Q_BITS-1:0]   low_r [Q_BITS];
  logic [R_BITS-1:0]   den_r [Q_BITS];
  logic                sg_r  [Q_BITS];
  logic                ovf_r [Q_BITS];

  assign mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      mag0_r <= mag;
      den0_r <= den;
      sg0_r  <= num[NUM_BITS-1];
      ovf0_r <= OVCMP_BITS'(mag[NUM_BITS-1:Q_BITS]) >= OVCMP_BITS'(den);
    end
  end

  for (genvar j = 0; j < Q_BITS; j++) begin : g_step
    logic [R_BITS-1:0] rem_in;
    logic [Q_BITS-1:0] q_in;
    logic [Q_BITS-1:0] low_in;
    logic [R_BITS-1:0] den_in;
    logic              sg_in;
    logic              ovf_in;
    logic [R_BITS:0]   t;
    if (j == 0) begin : g_first
      assign rem_in = R_BITS'(mag0_r[NUM_BITS-1:Q_BITS]);
      assign q_in   = '0;
      assign low_in = mag0_r[Q_BITS-1:0];
      assign den_in = den0_r;
      assign sg_in  = sg0_r;
      assign ovf_in = ovf0_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign low_in = low_r[j-1];
      assign den_in = den_r[j-1];
      assign sg_in  = sg_r[j-1];
      assign ovf_in = ovf_r[j-1];
    end
    assign t = {rem_in, low_in[Q_BITS-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, den_in}) begin
          rem_r[j] <= R_BITS'(t - {1'b0, den_in});
          q_r[j]   <= {q_in[Q_BITS-2:0], 1'b1};
        end else begin
          rem_r[j] <= t[R_BITS-1:0];
          q_r[j]   <= {q_in[Q_BITS-2:0], 1'b0};
        end
        low_r[j] <= {low_in[Q_BITS-2:0], 1'b0};
        den_r[j] <= den_in;
        sg_r[j]  <= sg_in;
        ovf_r[j] <= ovf_in;
      end
    end
  end

  assign q_out   = q_r[Q_BITS-1];
  assign neg_out = sg_r[Q_BITS-1];
  assign ovf_out = ovf_r[Q_BITS-1];

endmodule
